>>> rtl/core/fcbb_pkg.sv
// Shared types and constants for the frame content bounding box block.
// Holds the register map, field widths and the structs passed between
// the register file, the tracker and the top level. No dependencies.
package fcbb_pkg;

   localparam int PIXEL_W       = 24;
   localparam int DIM_REG_W     = 13;
   localparam int POS_W         = 12;
   localparam int SIZE_W        = 13;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 24;
   localparam int RSP_TDATA_W   = 56;
   localparam int MAX_DIM_DFLT  = 4096;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BACKGROUND   = 2'd2;

   localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST  = 13'd4096;
   localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST = 13'd4096;
   localparam logic [PIXEL_W-1:0]   BACKGROUND_RST   = 24'd0;

   typedef struct packed {
      logic [DIM_REG_W-1:0] frame_width;
      logic [DIM_REG_W-1:0] frame_height;
      logic [PIXEL_W-1:0]   background_color;
   } cfg_type;

   typedef struct packed {
      logic              solid_frame;
      logic [POS_W-1:0]  crop_left;
      logic [POS_W-1:0]  crop_top;
      logic [SIZE_W-1:0] crop_width;
      logic [SIZE_W-1:0] crop_height;
   } crop_type;

endpackage

>>> rtl/core/frame_content_bounding_box.sv
// Top level of the frame content bounding box block: input register,
// configuration registers, tracker and result register.
// Depends on fcbb_pkg, fcbb_csr and fcbb_tracker.
//
//   channel  direction  payload
//   req      in         tdata: pixel_value
//   rsp      out        tuser: solid_frame; tdata: crop window
//   csr      in         index + data: frame_width, frame_height, background
//
// One pixel per cycle while no result is held back by rsp_tready; the frame's
// last pixel is taken into the input register, and the result register loads
// from it when that pixel steps the tracker, which raises rsp_tvalid.
// Synchronous active-high reset clears the frame counters, the box and both
// valid flags and loads the register defaults (4096 x 4096, black).
// A result held by rsp_tready low stalls the input register, and req_tready
// drops once that register is also full.
module frame_content_bounding_box #(
   parameter int MAX_DIM = fcbb_pkg::MAX_DIM_DFLT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fcbb_pkg::PIXEL_W-1:0]       req_tdata,   // [23:0] pixel_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] crop_left, [23:12] crop_top, [36:24] crop_width,
   // [49:37] crop_height, [55:50] zero
   output logic [fcbb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [0:0]                         rsp_tuser,   // [0] solid_frame
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fcbb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fcbb_pkg::CSR_DATA_W-1:0]    csr_data
);

   fcbb_pkg::cfg_type  cfg;
   fcbb_pkg::crop_type crop;
   logic               frame_end;

   logic                         pix_valid_ff, pix_valid_in;
   logic [fcbb_pkg::PIXEL_W-1:0] pix_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   fcbb_pkg::crop_type           rsp_ff;
   logic                         advance;
   logic                         step;
   logic                         req_take;

   fcbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fcbb_tracker #(
      .MAX_DIM (MAX_DIM)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .pixel     (pix_ff),
      .frame_end (frame_end),
      .crop      (crop)
   );

   // hold the input register while a result waits
   assign advance    = !(rsp_valid_ff && !rsp_tready);
   assign step       = pix_valid_ff && advance;
   assign req_tready = !pix_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      pix_valid_in = pix_valid_ff;
      if (req_take) begin
         pix_valid_in = 1'b1;
      end else if (advance) begin
         pix_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_ff <= req_tdata;
      end
      if (step && frame_end) begin
         rsp_ff <= crop;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.solid_frame;
   assign rsp_tdata  = {6'd0, rsp_ff.crop_height, rsp_ff.crop_width,
                        rsp_ff.crop_top, rsp_ff.crop_left};

   a_result_after_frame: assert property (@(posedge clock) disable iff (reset)
      (step && frame_end) |=> rsp_valid_ff)
      else $error("last pixel did not load a result");

   a_solid_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("solid frame result carries a window");

   a_no_step_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("held result overwritten");

endmodule

>>> rtl/core/fcbb_csr.sv
// Configuration registers of the frame content bounding box block.
// Decodes writes on the csr channel into frame size and background color.
// Depends on fcbb_pkg.
module fcbb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fcbb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fcbb_pkg::CSR_DATA_W-1:0]   csr_data,
   output fcbb_pkg::cfg_type                 cfg
);

   fcbb_pkg::cfg_type cfg_ff;
   fcbb_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fcbb_pkg::REG_FRAME_WIDTH: begin
               cfg_in.frame_width = csr_data[fcbb_pkg::DIM_REG_W-1:0];
            end
            fcbb_pkg::REG_FRAME_HEIGHT: begin
               cfg_in.frame_height = csr_data[fcbb_pkg::DIM_REG_W-1:0];
            end
            fcbb_pkg::REG_BACKGROUND: begin
               cfg_in.background_color = csr_data[fcbb_pkg::PIXEL_W-1:0];
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width      <= fcbb_pkg::FRAME_WIDTH_RST;
         cfg_ff.frame_height     <= fcbb_pkg::FRAME_HEIGHT_RST;
         cfg_ff.background_color <= fcbb_pkg::BACKGROUND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/fcbb_tracker.sv
// Raster position counters and running content box.
// Updates on each pixel step and forms the crop window on the last pixel.
// Depends on fcbb_pkg.
module fcbb_tracker #(
   parameter int MAX_DIM = fcbb_pkg::MAX_DIM_DFLT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fcbb_pkg::cfg_type              cfg,
   input  logic                           step,
   input  logic [fcbb_pkg::PIXEL_W-1:0]   pixel,
   output logic                           frame_end,
   output fcbb_pkg::crop_type             crop
);

   localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = CW + 1;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] lcol_ff, lcol_in;
   logic [CW-1:0] gcol_ff, gcol_in;
   logic [CW-1:0] lrow_ff, lrow_in;
   logic [CW-1:0] grow_ff, grow_in;
   logic          seen_ff, seen_in;

   logic [CW-1:0] lcol_up, gcol_up, lrow_up, grow_up;
   logic          seen_up;

   logic [DW-1:0] w_eff, h_eff;
   logic          row_end;
   logic          content;
   logic [DW-1:0] span_col, span_row;

   // Zero acts as one, anything above MAX_DIM as MAX_DIM.
   function automatic logic [DW-1:0] eff_dim(input logic [fcbb_pkg::DIM_REG_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DW'(MAX_DIM);
      end else begin
         r = DW'(32'(v));
      end
      return r;
   endfunction

   assign w_eff     = eff_dim(cfg.frame_width);
   assign h_eff     = eff_dim(cfg.frame_height);
   assign row_end   = ({1'b0, col_ff} + DW'(1)) >= w_eff;
   assign frame_end = row_end && (({1'b0, row_ff} + DW'(1)) >= h_eff);
   assign content   = (pixel != cfg.background_color);

   // widen the box with the current pixel
   always_comb begin
      lcol_up = lcol_ff;
      gcol_up = gcol_ff;
      lrow_up = lrow_ff;
      grow_up = grow_ff;
      seen_up = seen_ff;
      if (step && content) begin
         if (!seen_ff) begin
            lcol_up = col_ff;
            gcol_up = col_ff;
            lrow_up = row_ff;
            grow_up = row_ff;
            seen_up = 1'b1;
         end else begin
            if (col_ff < lcol_ff) lcol_up = col_ff;
            if (col_ff > gcol_ff) gcol_up = col_ff;
            if (row_ff < lrow_ff) lrow_up = row_ff;
            if (row_ff > grow_ff) grow_up = row_ff;
         end
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      lcol_in = lcol_up;
      gcol_in = gcol_up;
      lrow_in = lrow_up;
      grow_in = grow_up;
      seen_in = seen_up;
      if (step) begin
         priority if (frame_end) begin
            // clear for the next frame
            col_in  = '0;
            row_in  = '0;
            lcol_in = '0;
            gcol_in = '0;
            lrow_in = '0;
            grow_in = '0;
            seen_in = 1'b0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // The box of the last pixel itself must count, so build the window
   // from the updated box values.
   assign span_col = {1'b0, gcol_up} - {1'b0, lcol_up} + DW'(1);
   assign span_row = {1'b0, grow_up} - {1'b0, lrow_up} + DW'(1);

   always_comb begin
      crop = '0;
      if (seen_up) begin
         crop.solid_frame = 1'b0;
         crop.crop_left   = fcbb_pkg::POS_W'(32'(lcol_up));
         crop.crop_top    = fcbb_pkg::POS_W'(32'(lrow_up));
         crop.crop_width  = fcbb_pkg::SIZE_W'(32'(span_col));
         crop.crop_height = fcbb_pkg::SIZE_W'(32'(span_row));
      end else begin
         crop.solid_frame = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         lcol_ff <= '0;
         gcol_ff <= '0;
         lrow_ff <= '0;
         grow_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         lcol_ff <= lcol_in;
         gcol_ff <= gcol_in;
         lrow_ff <= lrow_in;
         grow_ff <= grow_in;
         seen_ff <= seen_in;
      end
   end

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (lcol_ff <= gcol_ff) && (lrow_ff <= grow_ff))
      else $error("content box inverted");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (step && frame_end) |=> (col_ff == '0) && (row_ff == '0) && !seen_ff)
      else $error("frame state not cleared after last pixel");

endmodule

>>> tb/sv/crop_window_pkg.sv
// Crop window predictor and result scoreboard for the frame content
// bounding box testbench. Depends on fcbb_pkg for widths, register
// indexes and the crop result struct.
package crop_window_pkg;
   import fcbb_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   class crop_window_tracker;
      logic [DIM_REG_W-1:0] width_reg;
      logic [DIM_REG_W-1:0] height_reg;
      logic [PIXEL_W-1:0]   background;
      logic [POS_W-1:0]     x_pos;
      logic [POS_W-1:0]     y_pos;
      logic [POS_W-1:0]     left_edge;
      logic [POS_W-1:0]     right_edge;
      logic [POS_W-1:0]     top_edge;
      logic [POS_W-1:0]     bottom_edge;
      bit                   content_seen;
      crop_type             pending_crops[$];
      int unsigned          mismatches;

      function new();
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         background = BACKGROUND_RST;
         mismatches = 0;
         clear_box();
      endfunction

      function void clear_box();
         x_pos        = '0;
         y_pos        = '0;
         left_edge    = '0;
         right_edge   = '0;
         top_edge     = '0;
         bottom_edge  = '0;
         content_seen = 1'b0;
      endfunction

      // A size of zero counts as one, anything past the maximum as the maximum.
      function int effective_dim(logic [DIM_REG_W-1:0] value);
         if (value == 0)
            return 1;
         if (value > MAX_DIM_DFLT)
            return MAX_DIM_DFLT;
         return int'(value);
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_FRAME_WIDTH:  width_reg  = data[DIM_REG_W-1:0];
            REG_FRAME_HEIGHT: height_reg = data[DIM_REG_W-1:0];
            REG_BACKGROUND:   background = data[PIXEL_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] pixel);
         int       cols;
         int       rows;
         bit       row_done;
         bit       frame_done;
         crop_type crop;
         cols = effective_dim(width_reg);
         rows = effective_dim(height_reg);
         if (pixel != background) begin
            if (!content_seen) begin
               left_edge    = x_pos;
               right_edge   = x_pos;
               top_edge     = y_pos;
               bottom_edge  = y_pos;
               content_seen = 1'b1;
            end else begin
               if (x_pos < left_edge) left_edge = x_pos;
               if (x_pos > right_edge) right_edge = x_pos;
               if (y_pos < top_edge) top_edge = y_pos;
               if (y_pos > bottom_edge) bottom_edge = y_pos;
            end
         end
         // a shrunken size ends the row or frame as soon as it is reached or passed
         row_done   = (int'(x_pos) + 1 >= cols);
         frame_done = row_done && (int'(y_pos) + 1 >= rows);
         if (!frame_done) begin
            if (row_done) begin
               x_pos = '0;
               y_pos = y_pos + 1'b1;
            end else begin
               x_pos = x_pos + 1'b1;
            end
         end else begin
            crop = '0;
            if (content_seen) begin
               crop.crop_left   = left_edge;
               crop.crop_top    = top_edge;
               crop.crop_width  = SIZE_W'(right_edge) - SIZE_W'(left_edge) + 1'b1;
               crop.crop_height = SIZE_W'(bottom_edge) - SIZE_W'(top_edge) + 1'b1;
            end else begin
               crop.solid_frame = 1'b1;
            end
            pending_crops.insert(pending_crops.size(), crop);
            clear_box();
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_crop(logic solid, logic [RSP_TDATA_W-1:0] data);
         crop_type want;
         if (pending_crops.size() == 0) begin
            $error("crop window with no frame end pending: solid_frame %0b tdata %h",
                   solid, data);
            mismatches++;
            return;
         end
         want = pending_crops.pop_front();
         compare_field("solid_frame", want.solid_frame, solid);
         compare_field("crop_left", want.crop_left, data[POS_W-1:0]);
         compare_field("crop_top", want.crop_top, data[2*POS_W-1:POS_W]);
         compare_field("crop_width", want.crop_width, data[2*POS_W+SIZE_W-1:2*POS_W]);
         compare_field("crop_height", want.crop_height,
                       data[2*POS_W+2*SIZE_W-1:2*POS_W+SIZE_W]);
      endfunction
   endclass

endpackage

>>> tb/sv/testbench.sv
// Top of the frame content bounding box testbench: clock, reset, pixel and
// register drivers, result monitor and watchdog.
// Depends on fcbb_pkg, crop_window_pkg and frame_content_bounding_box.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fcbb_pkg::*;
   import crop_window_pkg::*;

   localparam int RANDOM_PIXELS  = 1640;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int QUIET_LIMIT    = 2000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   crop_window_tracker crop_check;
   int                 idle_stage    = 0;
   int                 pixels_sent   = 0;
   logic [PIXEL_W-1:0] current_bg    = '0;
   bit                 holdoff_armed = 1'b0;
   bit                 holdoff_done  = 1'b0;
   int                 holdoff_count = 0;
   int                 quiet_cycles  = 0;

   frame_content_bounding_box dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: one long hold-off when armed, otherwise random stalls by stage.
   always @(negedge clock) begin
      if (holdoff_armed && !holdoff_done) begin
         rsp_tready <= 1'b0;
         holdoff_count++;
         if (holdoff_count >= HOLDOFF_CYCLES) holdoff_done = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >=
                        ((idle_stage == 0) ? 45 : (idle_stage == 1) ? 23 : 0));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         crop_check.check_crop(rsp_tuser[0], rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [PIXEL_W-1:0] pick_pixel(int density);
      if ($urandom_range(99) >= density)
         return current_bg;
      case ($urandom_range(2))
         0: return ~current_bg;
         1: return current_bg ^ (PIXEL_W'(1) << $urandom_range(PIXEL_W - 1));
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic logic [DIM_REG_W-1:0] pick_dim();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6)
         return '0;
      if (roll < 14)
         return DIM_REG_W'($urandom_range(7, 24));
      return DIM_REG_W'($urandom_range(1, 6));
   endfunction

   // All tasks start and end at a falling edge.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel);
      while ($urandom_range(99) < ((idle_stage == 0) ? 23 : (idle_stage == 1) ? 45 : 0))
      begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      crop_check.note_pixel(pixel);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      while (crop_check.pending_crops.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes keep it high between them.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      crop_check.set_register(index, data);
      @(negedge clock);
   endtask

   task automatic program_frame(input logic [DIM_REG_W-1:0] cols,
                                input logic [DIM_REG_W-1:0] rows,
                                input logic [PIXEL_W-1:0] bg,
                                input bit poke_unused);
      logic [CSR_DATA_W-1:0] spare;
      wait_idle(SETTLE_CYCLES);
      // fill the unused upper bits with noise; the block must mask them
      spare = $urandom;
      write_register(REG_FRAME_WIDTH, {spare[CSR_DATA_W-1:DIM_REG_W], cols});
      spare = $urandom;
      write_register(REG_FRAME_HEIGHT, {spare[CSR_DATA_W-1:DIM_REG_W], rows});
      write_register(REG_BACKGROUND, bg);
      if (poke_unused) write_register(REG_UNUSED, CSR_DATA_W'($urandom));
      csr_valid  <= 1'b0;
      current_bg = bg;
   endtask

   task automatic random_phase();
      logic [DIM_REG_W-1:0] cols;
      logic [DIM_REG_W-1:0] rows;
      logic [PIXEL_W-1:0]   bg;
      int                   area;
      int                   frames;
      int                   density;
      cols = pick_dim();
      rows = pick_dim();
      case ($urandom_range(3))
         0: bg = '0;
         1: bg = '1;
         default: bg = PIXEL_W'($urandom);
      endcase
      program_frame(cols, rows, bg, $urandom_range(7) == 0);
      area   = crop_check.effective_dim(cols) * crop_check.effective_dim(rows);
      frames = (area > 64) ? 1 : $urandom_range(1, 5);
      repeat (frames) begin
         case ($urandom_range(4))
            0: density = 0;
            1: density = 5;
            2: density = 25;
            3: density = 60;
            default: density = 100;
         endcase
         repeat (area) send_pixel(pick_pixel(density));
      end
      // leave a frame open so the next setting lands mid-frame
      if (area > 1 && $urandom_range(3) == 0)
         repeat ($urandom_range(1, area - 1)) send_pixel(pick_pixel(30));
   endtask

   initial begin
      logic [PIXEL_W-1:0] opening [12];
      int                 random_start;
      opening = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000001,
                  24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
      crop_check = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one frame with content, then an all-background frame
      program_frame(13'd3, 13'd2, 24'h000000, 1'b1);
      foreach (opening[i]) send_pixel(opening[i]);
      // zero sizes act as one: every pixel closes a frame
      program_frame(13'd0, 13'd0, 24'hFFFFFF, 1'b0);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h7FFFFF);
      program_frame(13'd4, 13'd3, 24'h123456, 1'b0);
      repeat (3) send_pixel(24'h123456);
      send_pixel(24'hA5A5A5);
      send_pixel(24'h5A5A5A);
      // shrink the frame under way: the next pixel reaches both limits
      program_frame(13'd2, 13'd2, 24'h123456, 1'b0);
      send_pixel(24'h123456);

      // hold the receiver off while single-pixel frames keep coming
      program_frame(13'd1, 13'd1, 24'h000000, 1'b0);
      holdoff_armed = 1'b1;
      repeat (40) send_pixel(pick_pixel(50));

      // oversized width acts as the maximum; shrink it under way to close the row
      program_frame(13'h1FFF, 13'd0, 24'hFFFFFF, 1'b1);
      repeat (40) send_pixel(pick_pixel(20));
      program_frame(13'd1, 13'd1, 24'hFFFFFF, 1'b0);
      send_pixel(pick_pixel(50));

      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         idle_stage = (pixels_sent - random_start) * 3 / RANDOM_PIXELS;
         random_phase();
      end

      wait_idle(4 * SETTLE_CYCLES);
      if (crop_check.mismatches == 0 && crop_check.pending_crops.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/fcbb_pkg.sv
rtl/core/fcbb_csr.sv
rtl/core/fcbb_tracker.sv
rtl/core/frame_content_bounding_box.sv
tb/sv/crop_window_pkg.sv
tb/sv/testbench.sv
